### hdl/sqd_pkg.sv
// Shared constants, payload types and controller codes for the shortest queue dispatcher.
package sqd_pkg;

   localparam int MAX_SERVERS = 8;
   localparam int QUEUE_DEPTH = 16;
   localparam int SRV_W  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
   localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
   localparam int PTR_W  = $clog2(QUEUE_DEPTH);
   localparam int LEN_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int ADDR_W = $clog2(MAX_SERVERS * QUEUE_DEPTH);
   localparam int SLOTS  = MAX_SERVERS * QUEUE_DEPTH;
   localparam int TIME_W = 32;
   localparam int JOB_W  = 16;
   localparam int SVC_W  = 16;
   localparam int CFG_W  = 4;
   localparam int KIND_W = 2;
   localparam int IDX_W  = 3;

   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_ARRIVAL = 1'b1;

   localparam logic [KIND_W-1:0] KIND_DONE    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_QUEUED  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DROPPED = 2'd2;

   localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

   typedef struct packed {
      logic             operation;
      logic [JOB_W-1:0] job_id;
      logic [SVC_W-1:0] service_time;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [JOB_W-1:0]  done_job;
      logic [IDX_W-1:0]  server_index;
      logic [TIME_W-1:0] event_time;
      logic              last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [JOB_W-1:0] job_id;
      logic [SVC_W-1:0] service_time;
   } slot_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARRIVE,
      ST_READ,
      ST_CHECK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic arrive;
      logic read;
      logic check;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic arrival;
      logic last_server;
   } status_type;

endpackage

### hdl/sqd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sqd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/sqd_ctrl.sv
// Controller state machine: sequences arrivals and the per-server tick sweep.
module sqd_ctrl import sqd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = status.arrival ? ST_ARRIVE : ST_READ;
            end
         end
         ST_ARRIVE: begin
            cmd.arrive = 1'b1;
            state_in   = ST_IDLE;
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = status.last_server ? ST_FINISH : ST_READ;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

### hdl/sqd_datapath.sv
// Datapath: clock, per-server queue state, job store, shortest queue search, result register.
module sqd_datapath import sqd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  cmd_type          cmd,
   output status_type       status,
   input  req_type          req_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data
);

   logic [CFG_W-1:0]  active_ff, active_in;
   logic [TIME_W-1:0] time_ff, time_in;
   logic [SRV_W-1:0]  chosen_ff, chosen_in;
   logic [TIME_W-1:0] head_ff [MAX_SERVERS];
   logic [TIME_W-1:0] head_in [MAX_SERVERS];
   logic [PTR_W-1:0]  rp_ff [MAX_SERVERS];
   logic [PTR_W-1:0]  rp_in [MAX_SERVERS];
   logic [PTR_W-1:0]  wp_ff [MAX_SERVERS];
   logic [PTR_W-1:0]  wp_in [MAX_SERVERS];
   logic [LEN_W-1:0]  len_ff [MAX_SERVERS];
   logic [LEN_W-1:0]  len_in [MAX_SERVERS];
   req_type           req_ff, req_in;
   logic [SRV_W-1:0]  idx_ff, idx_in;
   logic [SRV_W-1:0]  best_ff, best_in;
   logic [LEN_W-1:0]  best_len_ff, best_len_in;
   rsp_type           pend_ff, pend_in;
   logic              pend_valid_ff, pend_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_wr_addr;
   logic [ADDR_W-1:0] ram_rd_addr;
   slot_type          ram_wr_data;
   slot_type          ram_rd_data;

   logic [CNT_W-1:0]  srv_count;
   logic              retire;
   logic [LEN_W-1:0]  fin_len;
   logic [SVC_W-1:0]  svc_fixed;
   logic [TIME_W-1:0] head_sum;

   sqd_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (SLOTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // servers in use, zero reads as one, clamped to the build size
   always_comb begin
      if (active_ff == '0) begin
         srv_count = CNT_W'(1);
      end else if (CNT_W'(active_ff) > CNT_W'(MAX_SERVERS)) begin
         srv_count = CNT_W'(MAX_SERVERS);
      end else begin
         srv_count = CNT_W'(active_ff);
      end
   end

   assign status.arrival     = (req_data.operation == OP_ARRIVAL);
   assign status.last_server = (CNT_W'(idx_ff) == (srv_count - CNT_W'(1)));
   assign csr_ready          = 1'b1;

   assign svc_fixed   = (req_ff.service_time == '0) ? SVC_W'(1) : req_ff.service_time;
   assign head_sum    = head_ff[idx_ff] + TIME_W'(ram_rd_data.service_time);
   assign retire      = (len_ff[idx_ff] != '0) && (head_sum == time_ff);
   assign fin_len     = retire ? (len_ff[idx_ff] - LEN_W'(1)) : len_ff[idx_ff];

   assign ram_rd_addr = ADDR_W'(idx_ff) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(rp_ff[idx_ff]);
   assign ram_wr_addr = ADDR_W'(chosen_ff) * ADDR_W'(QUEUE_DEPTH)
                        + ADDR_W'(wp_ff[chosen_ff]);
   assign ram_wr_data = '{job_id: req_ff.job_id, service_time: svc_fixed};

   always_comb begin
      active_in     = active_ff;
      time_in       = time_ff;
      chosen_in     = chosen_ff;
      head_in       = head_ff;
      rp_in         = rp_ff;
      wp_in         = wp_ff;
      len_in        = len_ff;
      req_in        = req_ff;
      idx_in        = idx_ff;
      best_in       = best_ff;
      best_len_in   = best_len_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = 1'b0;
      ram_we        = 1'b0;

      if (csr_valid) begin
         active_in = csr_data;
      end

      if (cmd.load) begin
         req_in = req_data;
         if (req_data.operation == OP_TICK) begin
            time_in       = time_ff + TIME_W'(1);
            idx_in        = '0;
            pend_valid_in = 1'b0;
         end
      end

      if (cmd.arrive) begin
         rsp_valid_in          = 1'b1;
         rsp_in.done_job       = req_ff.job_id;
         rsp_in.server_index   = IDX_W'(chosen_ff);
         rsp_in.event_time     = time_ff;
         rsp_in.last_of_run    = 1'b1;
         if (len_ff[chosen_ff] >= LEN_W'(QUEUE_DEPTH)) begin
            rsp_in.kind = KIND_DROPPED;
         end else begin
            rsp_in.kind = KIND_QUEUED;
            ram_we      = 1'b1;
            if (len_ff[chosen_ff] == '0) begin
               head_in[chosen_ff] = time_ff;
            end
            wp_in[chosen_ff]  = (wp_ff[chosen_ff] == PTR_W'(QUEUE_DEPTH - 1)) ?
                                '0 : wp_ff[chosen_ff] + PTR_W'(1);
            len_in[chosen_ff] = len_ff[chosen_ff] + LEN_W'(1);
         end
      end

      if (cmd.check) begin
         if (retire) begin
            // earlier completion goes out now; newest is held until we know if it is last
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
            end
            pend_valid_in        = 1'b1;
            pend_in.kind         = KIND_DONE;
            pend_in.done_job     = ram_rd_data.job_id;
            pend_in.server_index = IDX_W'(idx_ff);
            pend_in.event_time   = time_ff;
            pend_in.last_of_run  = 1'b0;
            rp_in[idx_ff]   = (rp_ff[idx_ff] == PTR_W'(QUEUE_DEPTH - 1)) ?
                              '0 : rp_ff[idx_ff] + PTR_W'(1);
            len_in[idx_ff]  = fin_len;
            head_in[idx_ff] = time_ff;
         end
         if ((idx_ff == '0) || (fin_len < best_len_ff)) begin
            best_in     = idx_ff;
            best_len_in = fin_len;
         end
         idx_in = idx_ff + SRV_W'(1);
      end

      if (cmd.finish) begin
         chosen_in = best_ff;
         if (pend_valid_ff) begin
            rsp_valid_in       = 1'b1;
            rsp_in             = pend_ff;
            rsp_in.last_of_run = 1'b1;
         end
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= ACTIVE_RESET;
         time_ff       <= '1;
         chosen_ff     <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < MAX_SERVERS; i++) begin
            head_ff[i] <= '0;
            rp_ff[i]   <= '0;
            wp_ff[i]   <= '0;
            len_ff[i]  <= '0;
         end
      end else begin
         active_ff     <= active_in;
         time_ff       <= time_in;
         chosen_ff     <= chosen_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         head_ff       <= head_in;
         rp_ff         <= rp_in;
         wp_ff         <= wp_in;
         len_ff        <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      idx_ff      <= idx_in;
      best_ff     <= best_in;
      best_len_ff <= best_len_in;
      pend_ff     <= pend_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### hdl/shortest_queue_dispatcher.sv
// Top level of the join-the-shortest-queue dispatcher.
//
// A word is taken on req_data at a rising edge with start high and busy low. A tick word
// advances the clock (first tick reads 0), retires each in-use server's head job whose start
// plus service time equals the clock, in server order, and then latches the in-use server
// with the shortest queue (lowest index on a tie). An arrival word joins the latched server
// and is acknowledged as queued or dropped (queue full). Results leave on rsp_data, one
// word a cycle, each valid for exactly one cycle while rsp_valid is high; there is no
// back-pressure, so the receiver must take every word as it comes. last_of_run marks the
// final word of an input; a tick that retires nothing gives no word at all.
// Sequencing: an arrival keeps busy high through the ARRIVE state after the accept edge. A
// tick walks the in-use servers one at a time through the job store, whose read is
// registered, so each server takes a READ and a CHECK state and a FINISH state closes the
// walk. Each completion is held back until the walk finds the next one, so that the last can
// be marked; after the result register, the final word of a tick is strobed in the cycle
// after the closing one, with busy already low. An arrival's word likewise appears in the
// first cycle after busy falls. The job store needs no clearing after reset; the block can
// take a word straight away. active_servers is written on the csr_ channel, always ready,
// and should only be changed while busy is low; zero is treated as one server.

module shortest_queue_dispatcher import sqd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  req_type          req_data,
   output logic             rsp_valid,
   output rsp_type          rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer
   sqd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // queue state, job store and result register
   sqd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
